[rtl/core/stochastic_heat_level_pair_core_assert.svh]
// Assertion macros for the stochastic heat level pair core.
// Used by modules that include this header; needs clk and rst in scope.
`ifndef STOCHASTIC_HEAT_LEVEL_PAIR_CORE_ASSERT_SVH
`define STOCHASTIC_HEAT_LEVEL_PAIR_CORE_ASSERT_SVH

// same-cycle implication
`define SHLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SHLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/shlp_pkg.sv]
// Shared types, constants and the stencil function of the heat level pair core.
// No dependencies.
package shlp_pkg;

  localparam int MAX_LEVEL_DEF    = 8;
  localparam int FRAC_BITS_DEF    = 28;
  localparam int LEVEL_W          = 4;
  localparam int COUNT_W          = 16;
  localparam int CFG_IDX_W        = 8;
  localparam int CFG_DATA_W       = 16;
  localparam int GRID_W           = 32;
  localparam int NSUM_W           = 36;
  localparam int ENERGY_W         = 63;
  localparam int OUT_DATA_W       = 128;
  localparam int SAMPLE_COUNT_RST = 100;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL        = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 8'd1;

  typedef struct packed {
    logic                     fine_en;
    logic                     coarse_en;
    logic                     sample_end;
    logic                     last;
    logic signed [GRID_W-1:0] fine_val;
    logic signed [GRID_W-1:0] coarse_val;
  } energy_in_t;

  // u + floor(lap/4) + noise, saturated to 32 bits
  function automatic logic signed [GRID_W-1:0] stencil(
    input logic signed [GRID_W-1:0] prev,
    input logic signed [GRID_W-1:0] old,
    input logic signed [GRID_W-1:0] next,
    input logic signed [NSUM_W-1:0] noise
  );
    logic signed [34:0] lap;
    logic signed [37:0] acc;
    lap = 35'(prev) + 35'(next) - (35'(old) <<< 1);
    acc = 38'(old) + 38'(lap >>> 2) + 38'(noise);
    if (acc > 38'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (acc < -38'sd2147483648) begin
      return 32'sh80000000;
    end
    return acc[GRID_W-1:0];
  endfunction

endpackage

[rtl/core/shlp_energy.sv]
// Energy path: square, scale to Q40, saturating accumulate, two-entry result buffer.
// Depends on shlp_pkg.
module shlp_energy #(
  parameter int FRAC_BITS = shlp_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 restart,
  input  shlp_pkg::energy_in_t                 ein,
  input  logic [shlp_pkg::LEVEL_W-1:0]         lv,
  output logic                                 busy,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [shlp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tlast
);

  localparam int EShift = 2 * FRAC_BITS - 40;
  localparam int RShift = (EShift >= 0) ? EShift : 0;
  localparam int LShift = (EShift < 0) ? -EShift : 0;
  localparam logic [63:0] Lim = 64'h7fff_ffff_ffff_ffff;

  shlp_pkg::energy_in_t s1;
  logic        en_f2, en_c2, end2, last2;
  logic [63:0] sq_f, sq_c;
  logic        emit, emit_last;
  logic [shlp_pkg::ENERGY_W-1:0] sum_f, sum_c;

  logic [31:0] mag_f, mag_c;
  logic [63:0] sc_f, sc_c, t_f, t_c, add_f, add_c;
  logic [shlp_pkg::ENERGY_W-1:0] pf, pc;
  logic [63:0] diff;
  logic [4:0]  shf;

  // second output entry, filled only while the first one waits on the receiver
  logic [shlp_pkg::OUT_DATA_W-1:0] new_data, spare_data;
  logic        spare_last, spare_valid, pop, pipe_any;

  always_comb begin
    mag_f = s1.fine_val[31] ? (~s1.fine_val + 32'd1) : s1.fine_val;
    mag_c = s1.coarse_val[31] ? (~s1.coarse_val + 32'd1) : s1.coarse_val;
    t_f   = sq_f >> RShift;
    t_c   = sq_c >> RShift;
    sc_f  = (t_f > (Lim >> LShift)) ? Lim : (t_f << LShift);
    sc_c  = (t_c > (Lim >> LShift)) ? Lim : (t_c << LShift);
    add_f = {1'b0, sum_f} + sc_f;
    add_c = {1'b0, sum_c} + sc_c;
    if (add_f > Lim) add_f = Lim;
    if (add_c > Lim) add_c = Lim;
    shf   = {1'b0, lv} + 5'd1;
    pf    = sum_f >> shf;
    pc    = (lv != '0) ? (sum_c >> lv) : '0;
    diff  = {1'b0, pf} - {1'b0, pc};
    new_data = {1'b0, pf, diff};
  end

  assign pop      = m_axis_tvalid && m_axis_tready;
  assign pipe_any = ein.sample_end | s1.sample_end | end2 | emit;

  always_ff @(posedge clk) begin
    // stage 2: squares
    sq_f <= {32'b0, mag_f} * {32'b0, mag_f};
    sq_c <= {32'b0, mag_c} * {32'b0, mag_c};
    last2 <= s1.last;
    emit_last <= last2;
    if (rst) begin
      s1.fine_en    <= 1'b0;
      s1.coarse_en  <= 1'b0;
      s1.sample_end <= 1'b0;
      en_f2 <= 1'b0;
      en_c2 <= 1'b0;
      end2  <= 1'b0;
      emit  <= 1'b0;
      sum_f <= '0;
      sum_c <= '0;
      m_axis_tvalid <= 1'b0;
      spare_valid   <= 1'b0;
    end else begin
      // stage 1: grid values
      s1    <= ein;
      en_f2 <= s1.fine_en;
      en_c2 <= s1.coarse_en;
      end2  <= s1.sample_end;
      emit  <= end2;
      // stage 3: accumulate; sums clear when the result is emitted or on restart
      if (restart || emit) begin
        sum_f <= '0;
        sum_c <= '0;
      end else begin
        if (en_f2) sum_f <= add_f[shlp_pkg::ENERGY_W-1:0];
        if (en_c2) sum_c <= add_c[shlp_pkg::ENERGY_W-1:0];
      end
      m_axis_tvalid <= (m_axis_tvalid && !pop) || spare_valid || emit;
      spare_valid   <= pop ? (spare_valid && emit) : (spare_valid || (emit && m_axis_tvalid));
    end
  end

  always_ff @(posedge clk) begin
    if (pop && spare_valid) begin
      m_axis_tdata <= spare_data;
      m_axis_tlast <= spare_last;
    end else if (emit && (!m_axis_tvalid || pop)) begin
      m_axis_tdata <= new_data;
      m_axis_tlast <= emit_last;
    end
    if (emit && ((m_axis_tvalid && !pop) || spare_valid)) begin
      spare_data <= new_data;
      spare_last <= emit_last;
    end
  end

  // a further sample end could overflow the two entries
  assign busy = (pipe_any && m_axis_tvalid) || (m_axis_tvalid && spare_valid);

endmodule

[rtl/core/stochastic_heat_level_pair_core.sv]
// Top level of the stochastic heat level pair core: grid memories and stencil.
// Depends on shlp_pkg, shlp_energy and stochastic_heat_level_pair_core_assert.svh.
//
// Usage
//   cfg channel: cfg_index 0 writes the level (low 4 bits) and restarts the run,
//   index 1 writes the sample count; other indexes are ignored. cfg_ready is
//   always high; write only while the core is idle.
//   s_axis: one noise increment per beat (tdata = signed Q3.28), interior fine
//   cells in order, then fine steps in order; a sample is 4^(level+1) steps.
//   m_axis: one beat per sample, tdata = {pad, fine energy, level difference},
//   tlast marks the sample that ends the configured count.
// Timing
//   One noise beat per cycle while s_axis_tready is high. Each beat does one read of
//   the fine grid memory at accept and one write in the next cycle; the left neighbor
//   and cell 1 are kept in registers, so a single read port per memory keeps up.
//   m_axis_tvalid rises after a sample's last beat passes the update and energy
//   stages. Results sit in a two-entry output buffer; s_axis_tready drops only for the
//   last beat of a sample while one result waits and a second is queued too.
// Reset
//   rst clears counters, energies, level 0 and sample count 100. The grids are
//   not cleared: the first step of each sample reads them as zero.
module stochastic_heat_level_pair_core #(
  parameter int MAX_LEVEL = shlp_pkg::MAX_LEVEL_DEF,
  parameter int FRAC_BITS = shlp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [shlp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [shlp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [31:0]                         s_axis_tdata,  // [31:0] noise_increment
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [63:0] level_difference, [126:64] fine_energy, [127] zero
  output logic [shlp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast   // last_sample
);

  `include "stochastic_heat_level_pair_core_assert.svh"

  localparam int FA = MAX_LEVEL + 1;      // fine address bits
  localparam int CA = MAX_LEVEL;          // coarse address bits
  localparam int FD = 1 << FA;
  localparam int CD = 1 << CA;
  localparam int SW = 2 * MAX_LEVEL + 2;  // fine step counter bits
  localparam int GW = shlp_pkg::GRID_W;
  localparam int NW = shlp_pkg::NSUM_W;

  // configuration
  logic [shlp_pkg::LEVEL_W-1:0] level;
  logic [shlp_pkg::COUNT_W-1:0] sample_count;
  logic [shlp_pkg::LEVEL_W-1:0] lv;
  logic                         restart;

  // sequencing counters
  logic [FA-1:0]                cell_index;
  logic [1:0]                   substep;
  logic [SW-1:0]                step;
  logic [shlp_pkg::COUNT_W-1:0] sample_index;

  // accept-side decode
  logic          s_acc;
  logic [FA:0]   nf, nf_m2, cell_ext, j_ext, j1_ext;
  logic [SW:0]   total_m1;
  logic [FA-1:0] c_ext, nc, cn_ext;
  logic          step_end, is_final, final_item, first, firstc;
  logic          c_act, odd, c_upd, cnextv, fnextv, last;
  logic [4:0]    sh_nf, sh_tot;

  // memories
  logic signed [GW-1:0] fine_mem   [FD];
  logic signed [GW-1:0] coarse_mem [CD];
  logic signed [NW-1:0] noise_mem  [CD];
  logic signed [GW-1:0] fine_rdata, coarse_rdata;
  logic signed [NW-1:0] noise_rdata;

  // update stage
  logic                 b_valid, b_first, b_fnextv, b_jone, b_step_end;
  logic                 b_cact, b_odd, b_ss0, b_cupd, b_firstc, b_cnextv, b_cone;
  logic                 b_final, b_sample_end, b_last;
  logic [FA-1:0]        b_j;
  logic [CA-1:0]        b_caddr;
  logic signed [GW-1:0] b_dw;

  logic signed [GW-1:0] old_hold, fine1, prev_old_fine;
  logic signed [GW-1:0] coarse_old_hold, coarse1, prev_old_coarse, odd_dw;
  logic signed [GW-1:0] old_f, next_f, nv_f, old_c, next_c, nv_c;
  logic signed [NW-1:0] noise_sum;

  shlp_pkg::energy_in_t ein;
  logic                 e_busy, busy;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && (cfg_index == shlp_pkg::REG_LEVEL);
  assign lv        = (level > shlp_pkg::LEVEL_W'(MAX_LEVEL)) ?
                     shlp_pkg::LEVEL_W'(MAX_LEVEL) : level;

  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= '0;
      sample_count <= shlp_pkg::COUNT_W'(shlp_pkg::SAMPLE_COUNT_RST);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        shlp_pkg::REG_LEVEL:        level        <= cfg_data[shlp_pkg::LEVEL_W-1:0];
        shlp_pkg::REG_SAMPLE_COUNT: sample_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- accept decode
  always_comb begin
    sh_nf      = {1'b0, lv} + 5'd1;
    sh_tot     = {lv, 1'b0} + 5'd2;
    nf         = (FA+1)'(1) << sh_nf;
    nf_m2      = nf - (FA+1)'(2);
    total_m1   = ((SW+1)'(1) << sh_tot) - (SW+1)'(1);
    cell_ext   = {1'b0, cell_index};
    j_ext      = cell_ext + (FA+1)'(1);
    j1_ext     = cell_ext + (FA+1)'(2);
    step_end   = (cell_ext == nf_m2);
    is_final   = ({1'b0, step} == total_m1);
    final_item = step_end && is_final;
    first      = (step == '0);
    firstc     = (step < SW'(4));
    fnextv     = (j1_ext < nf);
    c_ext      = j1_ext[FA:1];
    nc         = nf[FA:1];
    cn_ext     = c_ext + FA'(1);
    c_act      = (lv != '0) && !step_end;
    odd        = j_ext[0];
    c_upd      = c_act && (substep == 2'd3) && !odd;
    cnextv     = (cn_ext < nc);
    last       = ({1'b0, sample_index} + 17'd1) >= {1'b0, sample_count};
  end

  // the last beat of a sample waits only when the output buffer could overflow
  assign busy          = e_busy;
  assign s_axis_tready = !(final_item && busy);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      cell_index   <= '0;
      substep      <= '0;
      step         <= '0;
      sample_index <= '0;
    end else if (s_acc) begin
      if (step_end) begin
        cell_index <= '0;
        if (is_final) begin
          step         <= '0;
          substep      <= '0;
          sample_index <= last ? '0 : sample_index + 1'b1;
        end else begin
          step    <= step + 1'b1;
          substep <= substep + 2'd1;
        end
      end else begin
        cell_index <= cell_index + 1'b1;
      end
    end
  end

  // ------------------------------------------------------------- memories
  // reads issue at accept; writes come from the update stage
  always_ff @(posedge clk) begin
    if (s_acc) begin
      fine_rdata <= fine_mem[j1_ext[FA-1:0]];
    end
    if (s_acc && c_act && odd) begin
      noise_rdata <= noise_mem[c_ext[CA-1:0]];
    end
    if (s_acc && c_upd) begin
      coarse_rdata <= coarse_mem[cn_ext[CA-1:0]];
    end
    if (b_valid) begin
      fine_mem[b_j] <= nv_f;
    end
    if (b_valid && b_cact && !b_odd) begin
      noise_mem[b_caddr] <= noise_sum;
    end
    if (b_valid && b_cupd) begin
      coarse_mem[b_caddr] <= nv_c;
    end
  end

  // ---------------------------------------------------------- update stage
  always_ff @(posedge clk) begin
    if (s_acc) begin
      b_dw         <= s_axis_tdata;
      b_j          <= j_ext[FA-1:0];
      b_jone       <= (j_ext == (FA+1)'(1));
      b_first      <= first;
      b_fnextv     <= fnextv;
      b_step_end   <= step_end;
      b_cact       <= c_act;
      b_odd        <= odd;
      b_ss0        <= (substep == 2'd0);
      b_cupd       <= c_upd;
      b_firstc     <= firstc;
      b_cnextv     <= cnextv;
      b_cone       <= (c_ext == FA'(1));
      b_caddr      <= c_ext[CA-1:0];
      b_final      <= is_final;
      b_sample_end <= final_item;
      b_last       <= last;
    end
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= s_acc;
    end
  end

  always_comb begin
    // fine cell: left neighbor is the pre-update value kept from the last beat
    old_f  = b_first ? '0 : (b_jone ? fine1 : old_hold);
    next_f = (b_first || !b_fnextv) ? '0 : fine_rdata;
    nv_f   = shlp_pkg::stencil(prev_old_fine, old_f, next_f, NW'(b_dw));
    // coarse noise: pair of fine increments added to the running 4-substep sum
    noise_sum = (b_ss0 ? NW'(0) : noise_rdata) + NW'(odd_dw) + NW'(b_dw);
    old_c  = b_firstc ? '0 : (b_cone ? coarse1 : coarse_old_hold);
    next_c = (b_firstc || !b_cnextv) ? '0 : coarse_rdata;
    nv_c   = shlp_pkg::stencil(prev_old_coarse, old_c, next_c, noise_sum >>> 1);
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      old_hold <= fine_rdata;
      if (b_jone) fine1 <= nv_f;
      if (b_cact && b_odd) odd_dw <= b_dw;
      if (b_cupd) begin
        coarse_old_hold <= coarse_rdata;
        if (b_cone) coarse1 <= nv_c;
      end
    end
    if (rst || restart) begin
      prev_old_fine   <= '0;
      prev_old_coarse <= '0;
    end else if (b_valid) begin
      prev_old_fine <= b_step_end ? '0 : old_f;
      if (b_step_end) begin
        prev_old_coarse <= '0;
      end else if (b_cupd) begin
        prev_old_coarse <= old_c;
      end
    end
  end

  // ----------------------------------------------------------- energy path
  always_comb begin
    ein.fine_en    = b_valid && b_final;
    ein.coarse_en  = b_valid && b_final && b_cupd;
    ein.sample_end = b_valid && b_sample_end;
    ein.last       = b_last;
    ein.fine_val   = nv_f;
    ein.coarse_val = nv_c;
  end

  shlp_energy #(
    .FRAC_BITS (FRAC_BITS)
  ) u_energy (
    .clk           (clk),
    .rst           (rst),
    .restart       (restart),
    .ein           (ein),
    .lv            (lv),
    .busy          (e_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // ------------------------------------------------------------ assertions
  `SHLP_ASSERT_NEXT(a_step_wrap, s_acc && step_end && !restart, cell_index == '0, "cell index did not wrap")
  `SHLP_ASSERT_NOW(a_coarse_level, b_valid && b_cupd, lv != '0, "coarse update at level 0")
  `SHLP_ASSERT_NEXT(a_sample_wrap, s_acc && final_item && !restart, (step == '0) && (substep == 2'd0), "sample did not restart")

endmodule

[tb/sv/tb_stochastic_heat_level_pair_core.sv]
// Self-checking testbench for stochastic_heat_level_pair_core: noise beats in,
// per-sample energy beats out, checked against an in-bench grid predictor.
// Depends on shlp_pkg and the core RTL.
module tb_stochastic_heat_level_pair_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FINE_CELLS   = 1 << (shlp_pkg::MAX_LEVEL_DEF + 1);
  localparam int          COARSE_CELLS = 1 << shlp_pkg::MAX_LEVEL_DEF;
  localparam int          SQ_SHIFT     = 2 * shlp_pkg::FRAC_BITS_DEF - 40;   // square to Q40
  localparam int          DRAIN_CYCLES = 12;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          ITEM_TARGET  = 1850;
  localparam longint unsigned E_MAX    = 64'h7fff_ffff_ffff_ffff;
  // indexes the core must ignore
  localparam logic [shlp_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd2;
  localparam logic [shlp_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 8'd255;

  typedef enum logic [1:0] {ROW_CFG, ROW_NOISE, ROW_KNOWN} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    logic [shlp_pkg::CFG_IDX_W-1:0] idx;
    logic [31:0]                    value;
    int                             reps;
    longint                         want_diff;
    logic [62:0]                    want_fine;
    logic                           want_last;
  } stim_row_t;

  typedef struct {
    longint      diff;
    logic [62:0] fine;
    logic        last;
  } sample_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [shlp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [shlp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [31:0]                     s_axis_tdata = '0;   // [31:0] noise_increment
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // [63:0] level_difference, [126:64] fine_energy, [127] zero
  logic [shlp_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;       // last_sample

  stochastic_heat_level_pair_core DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1ms;
    $display("tb_stochastic_heat_level_pair_core NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Grid predictor: shadow copy of the fine/coarse grids, counters and energies
  // ---------------------------------------------------------------------------
  logic [3:0]          shadow_level;
  logic [15:0]         shadow_count;
  logic signed [31:0]  fine_mem [FINE_CELLS];
  logic signed [31:0]  coarse_mem [COARSE_CELLS];
  longint              noise_pair_sum [COARSE_CELLS];
  logic signed [31:0]  left_fine, left_coarse;
  int unsigned         cell_pos, substep, step_num, sample_num;
  longint unsigned     energy_acc [2];

  sample_result_t      pending_results [$];
  int                  errors;
  int                  noise_sent;
  bit                  no_idle;      // phase with both sides running flat out
  bit                  hold_off_req; // ask the receiver for one long stall

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // explicit heat update: u + floor(lap/4) + noise
  function automatic logic signed [31:0] heat_update(logic signed [31:0] lft,
      logic signed [31:0] mid, logic signed [31:0] rgt, longint noise);
    longint lap;
    lap = longint'(lft) + longint'(rgt) - 2 * longint'(mid);
    return clamp32(longint'(mid) + (lap >>> 2) + noise);
  endfunction

  function automatic void accumulate_energy(int which, logic signed [31:0] v);
    longint unsigned mag, sq;
    mag = (v < 0) ? longint'(-longint'(v)) : longint'(v);
    sq  = (mag * mag) >> SQ_SHIFT;
    energy_acc[which] = (energy_acc[which] > E_MAX - sq) ? E_MAX : energy_acc[which] + sq;
  endfunction

  function automatic void restart_run();
    left_fine = 0;
    left_coarse = 0;
    cell_pos = 0;
    substep = 0;
    step_num = 0;
    sample_num = 0;
    energy_acc[0] = 0;
    energy_acc[1] = 0;
  endfunction

  function automatic void shadow_config(logic [shlp_pkg::CFG_IDX_W-1:0] idx,
                                        logic [31:0] value);
    if (idx == shlp_pkg::REG_LEVEL) begin
      shadow_level = value[3:0];
      restart_run();
    end else if (idx == shlp_pkg::REG_SAMPLE_COUNT) begin
      shadow_count = value[15:0];
    end
  endfunction

  // One noise beat through the grids; returns 1 when a sample completes.
  function automatic bit advance_grid(logic [31:0] raw, output sample_result_t res);
    int unsigned        lv, nf, nc, j, c;
    longint             dw;
    bit                 first_step, last_step, first_c, is_last;
    logic signed [31:0] mid, rgt, nv, midc, rgtc, cv;
    longint unsigned    pf, pc;
    lv = (shadow_level > shlp_pkg::MAX_LEVEL_DEF) ? shlp_pkg::MAX_LEVEL_DEF : shadow_level;
    nf = 1 << (lv + 1);
    dw = longint'($signed(raw));
    first_step = (step_num == 0);
    last_step  = (step_num == nf * nf - 1);
    res = '{0, '0, 1'b0};
    if (cell_pos >= nf - 1) cell_pos = 0;
    j = cell_pos + 1;
    mid = first_step ? 32'sd0 : fine_mem[j];
    rgt = (first_step || j + 1 >= nf) ? 32'sd0 : fine_mem[j + 1];
    nv = heat_update(left_fine, mid, rgt, dw);
    fine_mem[j] = nv;
    left_fine = mid;
    if (last_step) accumulate_energy(0, nv);

    if (lv > 0) begin
      nc = nf >> 1;
      c = (j + 1) >> 1;
      // top fine cell has no coarse partner
      if (c < nc) begin
        if (j[0] && substep == 0) noise_pair_sum[c] = dw;
        else noise_pair_sum[c] += dw;
        if (substep == 3 && !j[0]) begin
          first_c = (step_num < 4);
          midc = first_c ? 32'sd0 : coarse_mem[c];
          rgtc = (first_c || c + 1 >= nc) ? 32'sd0 : coarse_mem[c + 1];
          cv = heat_update(left_coarse, midc, rgtc, noise_pair_sum[c] >>> 1);
          coarse_mem[c] = cv;
          left_coarse = midc;
          if (last_step) accumulate_energy(1, cv);
        end
      end
    end

    cell_pos++;
    if (cell_pos < nf - 1) return 0;
    cell_pos = 0;
    left_fine = 0;
    left_coarse = 0;
    substep = (substep + 1) & 3;
    if (!last_step) begin
      step_num++;
      return 0;
    end

    pf = energy_acc[0] >> (lv + 1);
    pc = (lv > 0) ? (energy_acc[1] >> lv) : 64'd0;
    is_last = (sample_num + 1 >= shadow_count);  // count 0 acts as 1
    res.diff = longint'(pf) - longint'(pc);
    res.fine = pf[62:0];
    res.last = is_last;
    sample_num = is_last ? 0 : ((sample_num + 1) & 16'hffff);
    energy_acc[0] = 0;
    energy_acc[1] = 0;
    step_num = 0;
    substep = 0;
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0t %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Register writes only once every result is out and the pipe has drained.
  task automatic write_reg(logic [shlp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value[shlp_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    shadow_config(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one noise beat; a known result replaces the predicted one when given
  task automatic send_noise(logic [31:0] value, bit known, sample_result_t known_res);
    int gap;
    sample_result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = value;
    do @(posedge clk); while (!s_axis_tready);
    noise_sent++;
    if (advance_grid(value, res)) pending_results.push_back(known ? known_res : res);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_noise();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3, 4: return $urandom;
      default: return $urandom_range(0, 32'h1fff_ffff) - 32'h1000_0000;  // about +-1.0
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  stim_row_t directed [$];

  initial begin
    sample_result_t none_res, row_res;
    int lv, per_sample, n, sc_pick;
    bit held;
    errors = 0;
    noise_sent = 0;
    no_idle = 1'b0;
    hold_off_req = 1'b0;
    held = 1'b0;
    none_res = '{0, '0, 1'b0};
    shadow_level = 4'd0;
    shadow_count = 16'(shlp_pkg::SAMPLE_COUNT_RST);
    foreach (fine_mem[i]) fine_mem[i] = 0;
    foreach (coarse_mem[i]) coarse_mem[i] = 0;
    foreach (noise_pair_sum[i]) noise_pair_sum[i] = 0;
    restart_run();

    // level 0: one interior cell, four steps per sample
    directed.push_back('{ROW_CFG, shlp_pkg::REG_SAMPLE_COUNT, 32'd1, 1, 0, '0, 1'b0});
    directed.push_back('{ROW_KNOWN, '0, 32'h0000_0000, 4, 0, 63'd0, 1'b1});
    // full-scale positive saturates on every step after the first
    directed.push_back('{ROW_KNOWN, '0, 32'h7fff_ffff, 4,
                         64'd35184372056064, 63'd35184372056064, 1'b1});
    // full-scale negative saturates low
    directed.push_back('{ROW_KNOWN, '0, 32'h8000_0000, 4,
                         64'd35184372088832, 63'd35184372088832, 1'b1});
    // sample count zero behaves as one
    directed.push_back('{ROW_CFG, shlp_pkg::REG_SAMPLE_COUNT, 32'd0, 1, 0, '0, 1'b0});
    directed.push_back('{ROW_NOISE, '0, 32'h0000_0001, 1, 0, '0, 1'b0});
    directed.push_back('{ROW_NOISE, '0, 32'hffff_ffff, 1, 0, '0, 1'b0});
    directed.push_back('{ROW_NOISE, '0, 32'h5555_5555, 1, 0, '0, 1'b0});
    directed.push_back('{ROW_NOISE, '0, 32'haaaa_aaaa, 1, 0, '0, 1'b0});
    // count lowered below the running index: next result is last
    directed.push_back('{ROW_CFG, shlp_pkg::REG_SAMPLE_COUNT, 32'd3, 1, 0, '0, 1'b0});
    directed.push_back('{ROW_NOISE, '0, 32'h1000_0000, 8, 0, '0, 1'b0});
    directed.push_back('{ROW_CFG, shlp_pkg::REG_SAMPLE_COUNT, 32'd1, 1, 0, '0, 1'b0});
    directed.push_back('{ROW_NOISE, '0, 32'hf000_0000, 4, 0, '0, 1'b0});
    // unknown indexes are dropped
    directed.push_back('{ROW_CFG,   REG_UNUSED_LO, 32'hffff,        1, 0, '0, 1'b0});
    directed.push_back('{ROW_CFG,   REG_UNUSED_HI, 32'h0007,        1, 0, '0, 1'b0});
    directed.push_back('{ROW_NOISE, '0, 32'h0800_0000, 4, 0, '0, 1'b0});
    // levels above the maximum clamp; partial samples, then restart by level write
    directed.push_back('{ROW_CFG, shlp_pkg::REG_LEVEL, 32'd15, 1, 0, '0, 1'b0});
    directed.push_back('{ROW_NOISE, '0, 32'h0000_0003, 5, 0, '0, 1'b0});
    directed.push_back('{ROW_CFG, shlp_pkg::REG_LEVEL, 32'd8, 1, 0, '0, 1'b0});
    directed.push_back('{ROW_NOISE, '0, 32'h8000_0000, 3, 0, '0, 1'b0});
    directed.push_back('{ROW_CFG, shlp_pkg::REG_SAMPLE_COUNT, 32'd65535, 1, 0, '0, 1'b0});
    directed.push_back('{ROW_CFG, shlp_pkg::REG_LEVEL, 32'd1, 1, 0, '0, 1'b0});
    directed.push_back('{ROW_NOISE, '0, 32'h7fff_ffff, 48, 0, '0, 1'b0});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    m_axis_tready = 1'b1;

    foreach (directed[r]) begin
      if (directed[r].kind == ROW_CFG) begin
        write_reg(directed[r].idx, directed[r].value);
      end else begin
        row_res = '{directed[r].want_diff, directed[r].want_fine, directed[r].want_last};
        for (int k = 0; k < directed[r].reps; k++)
          send_noise(directed[r].value, directed[r].kind == ROW_KNOWN, row_res);
      end
    end

    // random phases: mostly whole samples at small levels, some partial runs
    // at deep levels, random sample counts including the extremes
    noise_sent = 0;
    while (noise_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: lv = 0;
        8, 9, 10, 11, 12, 13, 14, 15, 16: lv = 1;
        17:      lv = 2;
        default: lv = $urandom_range(3, 15);
      endcase
      if ($urandom_range(0, 4) != 0) write_reg(shlp_pkg::REG_LEVEL, 32'(lv));
      sc_pick = $urandom_range(0, 5);
      write_reg(shlp_pkg::REG_SAMPLE_COUNT, 32'(sc_pick == 0 ? 0 : sc_pick == 1 ? 65535 :
                sc_pick == 2 ? $urandom_range(1, 65535) : $urandom_range(1, 4)));
      no_idle = ($urandom_range(0, 3) == 0);
      if (!held) begin
        hold_off_req = 1'b1;
        held = 1'b1;
      end
      if (lv <= 2) begin
        per_sample = ((1 << (lv + 1)) - 1) * (1 << (2 * lv + 2));
        n = per_sample * $urandom_range(1, lv == 0 ? 12 : lv == 1 ? 3 : 1);
        if ($urandom_range(0, 3) == 0) n += $urandom_range(1, per_sample - 1);
      end else begin
        n = $urandom_range(1, 150);
      end
      for (int k = 0; k < n; k++) send_noise(pick_noise(), 1'b0, none_res);
    end

    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("tb_stochastic_heat_level_pair_core OK");
    end else begin
      $display("tb_stochastic_heat_level_pair_core NOT OK");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver and result check
  // ---------------------------------------------------------------------------
  initial begin
    sample_result_t want;
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        // long hold so the core backs up and stalls its input
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", m_axis_tdata[63:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[63:0] !== want.diff)
          report_mismatch("level_difference", m_axis_tdata[63:0], want.diff);
        if (m_axis_tdata[126:64] !== want.fine)
          report_mismatch("fine_energy", {1'b0, m_axis_tdata[126:64]}, {1'b0, want.fine});
        if (m_axis_tlast !== want.last)
          report_mismatch("last_sample", 64'(m_axis_tlast), 64'(want.last));
      end
      @(negedge clk);
    end
  end

endmodule
